// File: rtl/core/hdg_pkg.sv
// ============================================================================
// hdg_pkg
// Shared widths, constants and the arctangent table of the distance gate.
// ============================================================================
package hdg_pkg;

    // Number of CORDIC micro-rotations in both the rotation and vectoring units
    localparam int CORDIC_STAGES = 24;
    localparam int ATAN_COUNT    = 40;

    // Datapath widths
    localparam int ANG_W      = 33;   // angle in half-units of 5e-8 degree
    localparam int RED_W      = 35;   // angle during range reduction
    localparam int MAG_W      = 31;   // folded angle magnitude
    localparam int NUM_W      = 63;   // magnitude times pi
    localparam int XY_W       = 34;   // CORDIC x, y and z
    localparam int TRIG_W     = 32;   // sine and cosine, Q30
    localparam int QA_W       = 31;   // haversine term, [0, 1] in Q30
    localparam int SQ_W       = 62;   // square-root working registers
    localparam int SQRT_STEPS = 31;   // one result bit per step
    localparam int DIST_W     = 25;
    localparam int PROD_W     = 55;   // angle times two earth radii

    // Angle constants in half-units
    localparam logic signed [RED_W-1:0] FULL_TURN    = 35'sd7200000000;
    localparam logic signed [RED_W-1:0] HALF_TURN    = 35'sd3600000000;
    localparam logic signed [RED_W-1:0] QUARTER_TURN = 35'sd1800000000;
    localparam logic [31:0] HALF_TURN_U    = 32'd3600000000;
    localparam logic [31:0] QUARTER_TURN_U = 32'd1800000000;
    // floor(2^63 / HALF_TURN): reciprocal for the radian conversion
    localparam logic [31:0] TURN_RECIP     = 32'd2562047788;
    localparam logic [31:0] PI_Q30         = 32'd3373259426;

    localparam logic signed [XY_W-1:0] GAIN_INV = 34'sd652032874;
    localparam logic [QA_W-1:0]        Q_ONE    = 31'h40000000;
    localparam logic [23:0]            TWO_RADII = 24'd12742000;
    localparam logic [DIST_W-1:0]      DIST_MAX  = 25'd20100000;

    // Pipeline depths
    localparam int SINCOS_LAT = 8 + CORDIC_STAGES;
    localparam int LATENCY    = 1 + SINCOS_LAT + 3 + SQRT_STEPS + CORDIC_STAGES + 2;

    localparam logic [31:0] ATAN_TABLE [ATAN_COUNT] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
    };

    // Arctangent of 2^-idx in Q30, as a signed CORDIC operand
    function automatic logic signed [XY_W-1:0] atan_at(input int idx);
        logic [31:0] raw;
        raw = (idx < ATAN_COUNT) ? ATAN_TABLE[idx] : 32'd0;
        return $signed({2'b00, raw});
    endfunction

endpackage

// File: rtl/core/haversine_distance_gate.sv
// ============================================================================
// haversine_distance_gate
// Great-circle distance between two positions with a share threshold.
// ============================================================================
// Usage:
//   Input word: raise start for one cycle with both positions (lat/lon in
//   signed 1e-7 degree) on the input ports; busy stays low, so a word is
//   taken on every cycle that start is high.
//   Result word: done pulses for one cycle with distance_meters and
//   share_flag valid; the receiver must take it in that cycle.
//   The rotation and vectoring CORDIC pipelines (24 stages each) and the
//   31-step square root make up most of the pipeline. Throughput is one
//   word per cycle, every stage fully pipelined.
//   threshold_meters is written on any cycle that threshold_write is high;
//   zero makes share_flag always 1, otherwise share_flag means distance
//   above threshold.
//   Reset clears the threshold to zero and drops all words in flight.
// ============================================================================
module haversine_distance_gate
    import hdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] first_latitude,
    input  logic signed [31:0] first_longitude,
    input  logic signed [30:0] second_latitude,
    input  logic signed [31:0] second_longitude,
    input  logic               threshold_write,
    input  logic [DIST_W-1:0]  threshold_meters,
    output logic               done,
    output logic [DIST_W-1:0]  distance_meters,
    output logic               share_flag
);

    logic [LATENCY-1:0]       vld_reg;
    logic [DIST_W-1:0]        thr_reg;
    logic signed [ANG_W-1:0]  dlat_reg, dlon_reg, lat1_reg, lat2_reg;
    logic signed [TRIG_W-1:0] s_lat, s_lon, c1, c2, unused_s1, unused_s2;
    logic signed [TRIG_W-1:0] c_dlat, c_dlon;
    logic signed [TRIG_W-1:0] sl2_reg, cc_reg, so2_reg, sl2b_reg, t_reg;
    logic signed [32:0]       a_sum;
    logic [QA_W-1:0]          a_next, a_reg, b_reg;
    logic [QA_W-1:0]          root_a, root_b;
    logic signed [XY_W-1:0]   vx_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]   vy_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]   vz_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]   ang;
    logic [30:0]              ang_clamped;
    logic [PROD_W-1:0]        mprod_reg, rounded;
    logic [PROD_W-31:0]       dist_full;
    logic [DIST_W-1:0]        dist_next, dist_reg;
    logic                     share_reg;

    // Q30 product rounded half up
    function automatic logic signed [TRIG_W-1:0] qmul(
        input logic signed [TRIG_W-1:0] x,
        input logic signed [TRIG_W-1:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y) + 64'sd536870912;
        return TRIG_W'(p >>> 30);
    endfunction

    assign busy = 1'b0;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (threshold_write)
            thr_reg <= threshold_meters;
    end

    // Advance the valid marks alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
    end

    // Capture the half-angle differences and doubled latitudes
    always_ff @(posedge clk)
    begin
        dlat_reg <= ANG_W'(second_latitude) - ANG_W'(first_latitude);
        dlon_reg <= ANG_W'(second_longitude) - ANG_W'(first_longitude);
        lat1_reg <= ANG_W'(first_latitude) <<< 1;
        lat2_reg <= ANG_W'(second_latitude) <<< 1;
    end

    hdg_sincos u_sc_dlat (.clk(clk), .angle(dlat_reg), .sin_q30(s_lat), .cos_q30(c_dlat));
    hdg_sincos u_sc_dlon (.clk(clk), .angle(dlon_reg), .sin_q30(s_lon), .cos_q30(c_dlon));
    hdg_sincos u_sc_lat1 (.clk(clk), .angle(lat1_reg), .sin_q30(unused_s1), .cos_q30(c1));
    hdg_sincos u_sc_lat2 (.clk(clk), .angle(lat2_reg), .sin_q30(unused_s2), .cos_q30(c2));

    // Haversine term: sin^2(dlat/2) + cos1 cos2 sin^2(dlon/2), clamped to [0, 1]
    always_comb
    begin
        a_sum = 33'(sl2b_reg) + 33'(t_reg);
        if (a_sum[32])
            a_next = '0;
        else if (a_sum > $signed({2'b00, Q_ONE}))
            a_next = Q_ONE;
        else
            a_next = a_sum[QA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sl2_reg  <= qmul(s_lat, s_lat);
        cc_reg   <= qmul(c1, c2);
        so2_reg  <= qmul(s_lon, s_lon);
        sl2b_reg <= sl2_reg;
        t_reg    <= qmul(cc_reg, so2_reg);
        a_reg    <= a_next;
        b_reg    <= Q_ONE - a_next;
    end

    hdg_sqrt u_sqrt (
        .clk    (clk),
        .a_val  (a_reg),
        .b_val  (b_reg),
        .root_a (root_a),
        .root_b (root_b)
    );

    // Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a))
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_vec
            logic signed [XY_W-1:0] x_in, y_in, z_in;
            if (i == 0)
            begin : g_first
                assign x_in = $signed({3'b000, root_b});
                assign y_in = $signed({3'b000, root_a});
                assign z_in = '0;
            end
            else
            begin : g_next
                assign x_in = vx_reg[i-1];
                assign y_in = vy_reg[i-1];
                assign z_in = vz_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (y_in > 0)
                begin
                    vx_reg[i] <= x_in + (y_in >>> i);
                    vy_reg[i] <= y_in - (x_in >>> i);
                    vz_reg[i] <= z_in + atan_at(i);
                end
                else
                begin
                    vx_reg[i] <= x_in - (y_in >>> i);
                    vy_reg[i] <= y_in + (x_in >>> i);
                    vz_reg[i] <= z_in - atan_at(i);
                end
            end
        end
    endgenerate

    // Scale half the central angle by two earth radii to meters, round, saturate, compare
    assign ang         = vz_reg[CORDIC_STAGES-1];
    assign ang_clamped = ang[XY_W-1] ? '0 : ang[30:0];
    assign rounded     = mprod_reg + PROD_W'(32'h20000000);
    assign dist_full   = rounded[PROD_W-1:30];
    assign dist_next   = (dist_full > (PROD_W-30)'(DIST_MAX)) ? DIST_MAX
                                                             : dist_full[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        mprod_reg <= PROD_W'(ang_clamped) * PROD_W'(TWO_RADII);
        dist_reg  <= dist_next;
        share_reg <= (thr_reg == '0) || (dist_next > thr_reg);
    end

    assign done            = vld_reg[LATENCY-1];
    assign distance_meters = dist_reg;
    assign share_flag      = share_reg;

    // Checks on the result word and the haversine term
    a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> distance_meters <= DIST_MAX)
        else $error("distance above saturation limit");

    a_zero_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && thr_reg == '0) |-> share_flag)
        else $error("zero threshold must always share");

    a_share_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && thr_reg != '0) |-> (share_flag == (distance_meters > thr_reg)))
        else $error("share flag disagrees with threshold compare");

    a_hav_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SINCOS_LAT + 3] |-> ((32'(a_reg) + 32'(b_reg)) == 32'(Q_ONE)))
        else $error("haversine terms do not sum to one");

endmodule

// File: rtl/core/hdg_sincos.sv
// ============================================================================
// hdg_sincos
// Pipelined sine and cosine of an angle in half-units of 5e-8 degree:
// range reduction, exact radian conversion, rotation CORDIC.
// ============================================================================
module hdg_sincos
    import hdg_pkg::*;
(
    input  logic                     clk,
    input  logic signed [ANG_W-1:0]  angle,
    output logic signed [TRIG_W-1:0] sin_q30,
    output logic signed [TRIG_W-1:0] cos_q30
);

    localparam int NCOS_LEN = 6 + CORDIC_STAGES;

    logic signed [RED_W-1:0] ext;
    logic signed [RED_W-1:0] red_next, red_reg;
    logic signed [RED_W-1:0] fold;
    logic                    ncos_next;
    logic [MAG_W-1:0]        mag_next, mag_reg;
    logic [4:0]              nang_reg;
    logic [NCOS_LEN-1:0]     ncos_reg;
    logic [NUM_W-1:0]        num_next, num_reg, num4_reg, num5_reg;
    logic [63:0]             est_prod;
    logic [MAG_W-1:0]        q0_next, q0_reg, q05_reg;
    logic [NUM_W-1:0]        prod_next, prod_reg;
    logic [NUM_W:0]          lim1, lim2;
    logic [MAG_W-1:0]        q_next, q_reg;
    logic signed [XY_W-1:0]  theta_next, theta_reg;
    logic signed [XY_W-1:0]  cx_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]  cy_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0]  cz_reg [CORDIC_STAGES];
    logic signed [TRIG_W-1:0] sin_reg, cos_reg, xt;

    // Reduce into (-180, 180] degrees
    always_comb
    begin
        ext = RED_W'(angle);
        if (ext > HALF_TURN)
            red_next = ext - FULL_TURN;
        else if (ext <= -HALF_TURN)
            red_next = ext + FULL_TURN;
        else
            red_next = ext;
    end

    // Fold into [-90, 90]; the cosine flips sign when folded
    always_comb
    begin
        if (red_reg > QUARTER_TURN)
        begin
            fold      = HALF_TURN - red_reg;
            ncos_next = 1'b1;
        end
        else if (red_reg < -QUARTER_TURN)
        begin
            fold      = -HALF_TURN - red_reg;
            ncos_next = 1'b1;
        end
        else
        begin
            fold      = red_reg;
            ncos_next = 1'b0;
        end
        mag_next = fold[RED_W-1] ? MAG_W'(-fold) : MAG_W'(fold);
    end

    // Radians: floor((mag * pi + quarter) / half), reciprocal estimate then fix-up
    always_comb
    begin
        num_next  = NUM_W'(64'(mag_reg) * 64'(PI_Q30)) + NUM_W'(QUARTER_TURN_U);
        est_prod  = 64'(num_reg[NUM_W-1:31]) * 64'(TURN_RECIP);
        q0_next   = est_prod[62:32];
        prod_next = NUM_W'(64'(q0_reg) * 64'(HALF_TURN_U));
        lim1      = (NUM_W+1)'(prod_reg) + (NUM_W+1)'(HALF_TURN_U);
        lim2      = lim1 + (NUM_W+1)'(HALF_TURN_U);
        if ((NUM_W+1)'(num5_reg) >= lim2)
            q_next = q05_reg + MAG_W'(2);
        else if ((NUM_W+1)'(num5_reg) >= lim1)
            q_next = q05_reg + MAG_W'(1);
        else
            q_next = q05_reg;
        theta_next = nang_reg[4] ? -$signed({3'b000, q_reg}) : $signed({3'b000, q_reg});
    end

    // Advance the conversion stages
    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        mag_reg   <= mag_next;
        nang_reg  <= {nang_reg[3:0], fold[RED_W-1]};
        ncos_reg  <= {ncos_reg[NCOS_LEN-2:0], ncos_next};
        num_reg   <= num_next;
        num4_reg  <= num_reg;
        q0_reg    <= q0_next;
        num5_reg  <= num4_reg;
        q05_reg   <= q0_reg;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        theta_reg <= theta_next;
    end

    // Rotation CORDIC, one micro-rotation per stage
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_rot
            logic signed [XY_W-1:0] x_in, y_in, z_in;
            if (i == 0)
            begin : g_first
                assign x_in = GAIN_INV;
                assign y_in = '0;
                assign z_in = theta_reg;
            end
            else
            begin : g_next
                assign x_in = cx_reg[i-1];
                assign y_in = cy_reg[i-1];
                assign z_in = cz_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (!z_in[XY_W-1])
                begin
                    cx_reg[i] <= x_in - (y_in >>> i);
                    cy_reg[i] <= y_in + (x_in >>> i);
                    cz_reg[i] <= z_in - atan_at(i);
                end
                else
                begin
                    cx_reg[i] <= x_in + (y_in >>> i);
                    cy_reg[i] <= y_in - (x_in >>> i);
                    cz_reg[i] <= z_in + atan_at(i);
                end
            end
        end
    endgenerate

    // Restore the cosine sign
    assign xt = TRIG_W'(cx_reg[CORDIC_STAGES-1]);

    always_ff @(posedge clk)
    begin
        sin_reg <= TRIG_W'(cy_reg[CORDIC_STAGES-1]);
        cos_reg <= ncos_reg[NCOS_LEN-1] ? -xt : xt;
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// File: rtl/core/hdg_sqrt.sv
// ============================================================================
// hdg_sqrt
// Dual pipelined Q30 square root, one result bit per stage, for a and 1 - a.
// ============================================================================
module hdg_sqrt
    import hdg_pkg::*;
(
    input  logic             clk,
    input  logic [QA_W-1:0]  a_val,
    input  logic [QA_W-1:0]  b_val,
    output logic [QA_W-1:0]  root_a,
    output logic [QA_W-1:0]  root_b
);

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] res;
    } sq_state_t;

    sq_state_t a_reg [SQRT_STEPS];
    sq_state_t b_reg [SQRT_STEPS];
    sq_state_t a_init, b_init;

    // One restoring step with the given trial bit
    function automatic sq_state_t sq_step(input sq_state_t s, input logic [SQ_W-1:0] bit_v);
        sq_state_t o;
        logic [SQ_W-1:0] trial;
        trial = s.res + bit_v;
        if (s.n >= trial)
        begin
            o.n   = s.n - trial;
            o.res = (s.res >> 1) + bit_v;
        end
        else
        begin
            o.n   = s.n;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    always_comb
    begin
        a_init.n   = SQ_W'({a_val, 30'b0});
        a_init.res = '0;
        b_init.n   = SQ_W'({b_val, 30'b0});
        b_init.res = '0;
    end

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam logic [SQ_W-1:0] BIT_V = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            sq_state_t a_in, b_in;
            if (k == 0)
            begin : g_first
                assign a_in = a_init;
                assign b_in = b_init;
            end
            else
            begin : g_next
                assign a_in = a_reg[k-1];
                assign b_in = b_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                a_reg[k] <= sq_step(a_in, BIT_V);
                b_reg[k] <= sq_step(b_in, BIT_V);
            end
        end
    endgenerate

    assign root_a = a_reg[SQRT_STEPS-1].res[QA_W-1:0];
    assign root_b = b_reg[SQRT_STEPS-1].res[QA_W-1:0];

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the haversine distance gate: drives position pairs
// with random start gaps, predicts distance and share flag in fixed point,
// and compares every done word against the oldest pending prediction.
// ============================================================================

class distance_scoreboard;

    longint unsigned threshold;
    logic [24:0]     dist_q[$];
    logic            flag_q[$];
    int              errors;

    function new();
        threshold = 0;
        errors    = 0;
    endfunction

    // Sine and cosine (Q30) of an angle given in half-units of 5e-8 degree
    function void sincos(input longint h, output longint s, output longint c);
        longint r, theta, x, y, z, dx, dy;
        longint unsigned mag;
        bit neg_cos, neg_ang;
        neg_cos = 0;
        r = h % 64'sd7200000000;
        if (r < 0) r += 64'sd7200000000;
        if (r > 64'sd3600000000) r -= 64'sd7200000000;
        // fold into [-90, 90], flip the cosine
        if (r > 64'sd1800000000) begin
            r = 64'sd3600000000 - r;
            neg_cos = 1;
        end
        else if (r < -64'sd1800000000) begin
            r = -64'sd3600000000 - r;
            neg_cos = 1;
        end
        neg_ang = (r < 0);
        mag = neg_ang ? -r : r;
        theta = (mag * 64'd3373259426 + 64'd1800000000) / 64'd3600000000;
        if (neg_ang) theta = -theta;
        x = 652032874;
        y = 0;
        z = theta;
        for (int i = 0; i < hdg_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc(i);
            end
            else begin
                x += dx; y -= dy; z += arc(i);
            end
        end
        s = y;
        c = neg_cos ? -x : x;
    endfunction

    function longint arc(input int i);
        return (i < hdg_pkg::ATAN_COUNT) ? longint'(hdg_pkg::ATAN_TABLE[i]) : 0;
    endfunction

    function longint mulq(input longint a, input longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function longint sqrt_q30(input longint v);
        longint unsigned n, res, b;
        n = longint'(v) << 30;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Note an accepted input word and queue its expected result
    function void note_input(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        longint s_lat, s_lon, c1, c2, dummy, a, ra, rb, x, y, z, dx, dy, dist_m;
        sincos(lat2 - lat1, s_lat, dummy);
        sincos(lon2 - lon1, s_lon, dummy);
        sincos(2 * lat1, dummy, c1);
        sincos(2 * lat2, dummy, c2);
        a = mulq(s_lat, s_lat) + mulq(mulq(c1, c2), mulq(s_lon, s_lon));
        if (a < 0) a = 0;
        if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
        ra = sqrt_q30(a);
        rb = sqrt_q30((64'sd1 << 30) - a);
        // vectoring CORDIC on (rb, ra)
        x = rb;
        y = ra;
        z = 0;
        for (int i = 0; i < hdg_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arc(i);
            end
            else begin
                x -= dx; y += dy; z -= arc(i);
            end
        end
        if (z < 0) z = 0;
        dist_m = (z * 12742000 + (64'sd1 << 29)) >>> 30;
        if (dist_m > 20100000) dist_m = 20100000;
        dist_q.push_back(dist_m[24:0]);
        flag_q.push_back(threshold == 0 || longint'(dist_m) > threshold);
    endfunction

    // Compare a done word against the oldest prediction
    function void check_result(input logic [24:0] got_d, input logic flag);
        logic [24:0] exp_d;
        logic        exp_f;
        if (dist_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result dist=%0d flag=%0b", got_d, flag);
            return;
        end
        exp_d = dist_q.pop_front();
        exp_f = flag_q.pop_front();
        if (got_d !== exp_d || flag !== exp_f) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: dist exp %0d got %0d, flag exp %0b got %0b",
                         exp_d, got_d, exp_f, flag);
        end
    endfunction

endclass

module tb_top;
    import hdg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] first_latitude;
    logic signed [31:0] first_longitude;
    logic signed [30:0] second_latitude;
    logic signed [31:0] second_longitude;
    logic               threshold_write;
    logic [DIST_W-1:0]  threshold_meters;
    logic               done;
    logic [DIST_W-1:0]  distance_meters;
    logic               share_flag;

    distance_scoreboard sb;
    int                 cycles;
    bit                 gaps_on;

    haversine_distance_gate DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .threshold_write  (threshold_write),
        .threshold_meters (threshold_meters),
        .done             (done),
        .distance_meters  (distance_meters),
        .share_flag       (share_flag)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Note accepted words, check done words, watch the cycle budget
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_input(longint'(first_latitude), longint'(first_longitude),
                          longint'(second_latitude), longint'(second_longitude));
        if (rst_n && done)
            sb.check_result(distance_meters, share_flag);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Send one position pair, with an optional random gap first
    task automatic send_pair(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start            <= 1'b1;
        first_latitude   <= 31'(lat1);
        first_longitude  <= 32'(lon1);
        second_latitude  <= 31'(lat2);
        second_longitude <= 32'(lon2);
        do @(posedge clk); while (busy);
    endtask

    // Drain the pipeline, then write the threshold while idle
    task automatic set_threshold(input logic [24:0] value);
        start <= 1'b0;
        while (sb.dist_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        threshold_write  <= 1'b1;
        threshold_meters <= value;
        @(posedge clk);
        threshold_write  <= 1'b0;
        sb.threshold = 64'(value);
    endtask

    function automatic longint pick_lat();
        if ($urandom_range(0, 9) == 0) return longint'($signed($urandom()) >>> 1);
        return longint'($urandom_range(0, 1800000000)) - 900000000;
    endfunction

    function automatic longint pick_lon();
        if ($urandom_range(0, 9) == 0) return longint'($signed($urandom()));
        return longint'($urandom_range(0, 2147483647)) % 1800000001
               * ($urandom_range(0, 1) ? 1 : -1);
    endfunction

    // Random pairs: far apart, nearby, or full-range noise
    task automatic random_pairs(input int count);
        longint lat1, lon1, lat2, lon2;
        for (int k = 0; k < count; k++) begin
            lat1 = pick_lat();
            lon1 = pick_lon();
            if ($urandom_range(0, 2) == 0) begin
                lat2 = lat1 + longint'($urandom_range(0, 2000000)) - 1000000;
                lon2 = lon1 + longint'($urandom_range(0, 2000000)) - 1000000;
                if (lat2 > 1073741823 || lat2 < -1073741824) lat2 = lat1;
                if (lon2 > 2147483647 || lon2 < -2147483648) lon2 = lon1;
            end
            else begin
                lat2 = pick_lat();
                lon2 = pick_lon();
            end
            send_pair(lat1, lon1, lat2, lon2);
        end
    endtask

    initial
    begin
        sb               = new();
        cycles           = 0;
        gaps_on          = 1;
        rst_n            = 0;
        start            = 0;
        first_latitude   = 0;
        first_longitude  = 0;
        second_latitude  = 0;
        second_longitude = 0;
        threshold_write  = 0;
        threshold_meters = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: same point, poles, antipodes, field extremes, wraps
        send_pair(0, 0, 0, 0);
        send_pair(900000000, 0, -900000000, 0);
        send_pair(0, 0, 0, 1800000000);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(0, 0, 0, -1800000000);
        send_pair(1073741823, 2147483647, -1073741824, -2147483648);
        send_pair(-1073741824, -2147483648, 1073741823, 2147483647);
        send_pair(1073741823, 0, 0, 0);
        send_pair(-1073741824, 0, 900000000, 0);
        send_pair(0, 2147483647, 0, 0);
        send_pair(0, -2147483648, 0, 0);
        send_pair(452000000, 91000000, 452000010, 91000010);
        send_pair(452000000, 91000000, 452000000, 91000001);
        send_pair(900000000, 1234567, 900000000, -987654321);
        send_pair(-900000000, 0, -899999999, 1800000000);
        send_pair(0, 0, 1, 0);
        send_pair(1, 1, -1, -1);
        send_pair(1200000000 >> 1, 0, 600000000, 1800000000);
        random_pairs(120);

        set_threshold(25'd1);
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 1, 0);
        random_pairs(130);
        set_threshold(25'd20100000);
        send_pair(0, 0, 0, 1800000000);
        random_pairs(130);
        set_threshold(25'h1FFFFFF);
        random_pairs(130);
        set_threshold(25'($urandom_range(100000, 15000000)));
        random_pairs(130);
        set_threshold(25'd0);
        gaps_on = 0;
        random_pairs(130);

        start <= 1'b0;
        while (sb.dist_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.dist_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
